/* src/tsq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsq_pkg
// Shared types, constants and effect tables of the tone sequencer.
// ----------------------------------------------------------------------------
package tsq_pkg;

   // item field widths
   localparam int OP_W    = 2;
   localparam int MS_W    = 16;
   localparam int FX_W    = 3;
   localparam int IDX_W   = 6;
   localparam int FREQ_W  = 16;
   localparam int DUR_W   = 16;
   localparam int LEN_W   = 7;
   localparam int FXPOS_W = 2;

   // tone timer arithmetic
   localparam int               QUOT_W     = 20;
   localparam logic [QUOT_W-1:0] TICK_HZ   = 20'd1000000;
   localparam int               DIV_STEPS  = QUOT_W;
   localparam int               DIV_CNT_W  = $clog2(DIV_STEPS);
   localparam logic [15:0]      PERIOD_MAX = 16'hFFFF;
   localparam logic [15:0]      PERIOD_RST = 16'd1000;
   localparam int               SONG_MAX   = 64;
   localparam logic [FX_W-1:0]  NUM_EFFECTS = 3'd6;

   typedef enum logic [OP_W-1:0] {
      OP_TICK   = 2'd0,
      OP_START  = 2'd1,
      OP_EFFECT = 2'd2,
      OP_WRITE  = 2'd3
   } op_type;

   typedef enum logic {
      CSR_LENGTH = 1'b0,
      CSR_LOOP   = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      SRC_NONE,
      SRC_BG,
      SRC_FX
   } tone_src_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_TONE,
      ST_DIV,
      ST_COMMIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [FREQ_W-1:0] freq;
      logic [DUR_W-1:0]  dur;
   } note_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic exec;
      logic tone;
      logic commit;
      logic publish;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic tone_go;
      logic div_done;
      logic out_free;
   } ctrl_status_type;

   // number of notes in each effect
   function automatic logic [2:0] fx_len(input logic [FX_W-1:0] sel);
      logic [2:0] n;
      case (sel)
         3'd0:    n = 3'd2;
         3'd1:    n = 3'd3;
         3'd2:    n = 3'd2;
         3'd3:    n = 3'd4;
         3'd4:    n = 3'd4;
         3'd5:    n = 3'd4;
         default: n = 3'd0;
      endcase
      return n;
   endfunction

   // built-in effect notes, zero past the end of an effect
   function automatic note_type fx_note(input logic [FX_W-1:0] sel,
                                        input logic [FXPOS_W-1:0] pos);
      note_type t;
      t = '0;
      case ({sel, pos})
         5'b000_00: t = '{16'd1200, 16'd30};
         5'b000_01: t = '{16'd0,    16'd10};
         5'b001_00: t = '{16'd600,  16'd50};
         5'b001_01: t = '{16'd400,  16'd80};
         5'b001_10: t = '{16'd0,    16'd30};
         5'b010_00: t = '{16'd250,  16'd120};
         5'b010_01: t = '{16'd0,    16'd40};
         5'b011_00: t = '{16'd900,  16'd60};
         5'b011_01: t = '{16'd1100, 16'd60};
         5'b011_10: t = '{16'd1300, 16'd100};
         5'b011_11: t = '{16'd0,    16'd40};
         5'b100_00: t = '{16'd784,  16'd120};
         5'b100_01: t = '{16'd988,  16'd120};
         5'b100_10: t = '{16'd1175, 16'd220};
         5'b100_11: t = '{16'd0,    16'd60};
         5'b101_00: t = '{16'd523,  16'd150};
         5'b101_01: t = '{16'd494,  16'd150};
         5'b101_10: t = '{16'd440,  16'd300};
         5'b101_11: t = '{16'd0,    16'd80};
         default:   t = '0;
      endcase
      return t;
   endfunction

endpackage

/* src/tsq_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tsq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/tsq_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsq_div
// Restoring divider: tick rate over tone frequency, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module tsq_div (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [tsq_pkg::FREQ_W-1:0]   divisor,
   output logic [tsq_pkg::QUOT_W-1:0]   quotient,
   output logic                         done
);
   import tsq_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [FREQ_W-1:0]    dvs_ff, dvs_in;
   logic [FREQ_W-1:0]    rem_ff, rem_in;
   logic [QUOT_W-1:0]    qd_ff, qd_in;
   logic [FREQ_W:0]      rem_sh;
   logic                 ge;

   // one restoring step; dividend bits leave the top, quotient bits enter below
   always_comb begin
      rem_sh  = {rem_ff, qd_ff[QUOT_W-1]};
      ge      = (rem_sh >= {1'b0, dvs_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      qd_in   = qd_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         dvs_in  = divisor;
         rem_in  = '0;
         qd_in   = TICK_HZ;
      end else if (busy_ff) begin
         rem_in = ge ? FREQ_W'(rem_sh - {1'b0, dvs_ff}) : rem_sh[FREQ_W-1:0];
         qd_in  = {qd_ff[QUOT_W-2:0], ge};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // arithmetic registers
   always_ff @(posedge clock) begin
      dvs_ff <= dvs_in;
      rem_ff <= rem_in;
      qd_ff  <= qd_in;
   end

   assign quotient = qd_ff;
   assign done     = done_ff;

endmodule

/* src/tsq_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsq_ctrl
// Sequencing state machine: accept, decide, load tone, divide, publish.
// ----------------------------------------------------------------------------
module tsq_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  tsq_pkg::ctrl_status_type  status,
   output tsq_pkg::ctrl_cmd_type     cmd
);
   import tsq_pkg::*;

   state_type state_ff, state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_valid) state_in = ST_EXEC;
         ST_EXEC:   state_in = ST_TONE;
         ST_TONE:   state_in = status.tone_go ? ST_DIV : ST_DONE;
         ST_DIV:    if (status.div_done) state_in = ST_COMMIT;
         ST_COMMIT: state_in = ST_DONE;
         ST_DONE:   if (status.out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_EXEC:   cmd.exec    = 1'b1;
         ST_TONE:   cmd.tone    = 1'b1;
         ST_DIV:    cmd         = '0;
         ST_COMMIT: cmd.commit  = 1'b1;
         ST_DONE:   cmd.publish = status.out_free;
         default:   cmd         = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* src/tsq_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsq_datapath
// Song and effect state, note memory, tone divider and result register.
// ----------------------------------------------------------------------------
module tsq_datapath #(
   parameter int BACKGROUND_DEPTH = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  tsq_pkg::ctrl_cmd_type         cmd,
   output tsq_pkg::ctrl_status_type      status,
   input  logic [tsq_pkg::OP_W-1:0]      req_operation,
   input  logic [tsq_pkg::MS_W-1:0]      req_elapsed_ms,
   input  logic [tsq_pkg::FX_W-1:0]      req_effect_id,
   input  logic [tsq_pkg::IDX_W-1:0]     req_note_index,
   input  logic [tsq_pkg::FREQ_W-1:0]    req_note_frequency,
   input  logic [tsq_pkg::DUR_W-1:0]     req_note_duration,
   input  logic                          csr_write_enable,
   input  logic                          csr_index,
   input  logic [tsq_pkg::LEN_W-1:0]     csr_wdata,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [15:0]                   rsp_period_reload,
   output logic [15:0]                   rsp_compare_value,
   output logic                          rsp_reload_event,
   output logic                          rsp_background_active,
   output logic                          rsp_effect_active
);
   import tsq_pkg::*;

   localparam int MAW = (BACKGROUND_DEPTH > 1) ? $clog2(BACKGROUND_DEPTH) : 1;
   localparam logic [LEN_W-1:0] SONG_CAP =
      LEN_W'((BACKGROUND_DEPTH < SONG_MAX) ? BACKGROUND_DEPTH : SONG_MAX);

   // latched item
   op_type             op_ff;
   logic [MS_W-1:0]    el_ff;
   logic [FX_W-1:0]    id_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic [FREQ_W-1:0]  fr_ff;
   logic [DUR_W-1:0]   du_ff;

   // sequencer state
   logic [LEN_W-1:0]   len_ff, len_in;
   logic               loop_ff, loop_in;
   logic [IDX_W-1:0]   bg_pos_ff, bg_pos_in;
   logic [DUR_W-1:0]   bg_left_ff, bg_left_in;
   logic               bg_on_ff, bg_on_in;
   logic [FX_W-1:0]    fx_sel_ff, fx_sel_in;
   logic [FXPOS_W-1:0] fx_pos_ff, fx_pos_in;
   logic [DUR_W-1:0]   fx_left_ff, fx_left_in;
   logic               fx_on_ff, fx_on_in;
   logic               resume_ff, resume_in;
   logic [IDX_W-1:0]   saved_pos_ff, saved_pos_in;
   logic [DUR_W-1:0]   saved_left_ff, saved_left_in;
   logic [15:0]        period_ff, period_in;
   logic [15:0]        compare_ff, compare_in;
   logic               reloaded_ff, reloaded_in;

   // pending tone load
   tone_src_type       src_ff, src_in;
   logic               ld_left_ff, ld_left_in;
   logic               oob_ff, oob_in;
   logic [FREQ_W-1:0]  freq_ff, freq_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [15:0]        rsp_period_ff;
   logic [15:0]        rsp_compare_ff;
   logic               rsp_reload_ff;
   logic               rsp_bg_ff;
   logic               rsp_fx_ff;

   // helpers
   logic [LEN_W-1:0]   len_nz;
   logic [LEN_W-1:0]   eff_len;
   logic [2:0]         fx_nxt;
   logic [LEN_W-1:0]   bg_nxt;
   note_type           fx_next_note;
   note_type           fx_first_note;
   logic [IDX_W-1:0]   rd_pos;
   logic [IDX_W-1:0]   start_pos;
   logic [31:0]        rd_data;
   note_type           mem_note;
   logic [FREQ_W-1:0]  tone_freq;
   logic               wr_en;
   logic               div_start;
   logic [QUOT_W-1:0]  quotient;
   logic               div_done;
   logic [QUOT_W-1:0]  p_full;
   logic [15:0]        p_sat;

   // song length with zero read as one and capped by the memory
   assign len_nz  = (len_ff == '0) ? LEN_W'(1) : len_ff;
   assign eff_len = (len_nz > SONG_CAP) ? SONG_CAP : len_nz;

   assign fx_nxt        = {1'b0, fx_pos_ff} + 3'd1;
   assign bg_nxt        = {1'b0, bg_pos_ff} + LEN_W'(1);
   assign fx_next_note  = fx_note(fx_sel_ff, fx_nxt[FXPOS_W-1:0]);
   assign fx_first_note = fx_note(id_ff, '0);
   assign start_pos     = ({1'b0, bg_pos_ff} >= eff_len) ? '0 : bg_pos_ff;

   // note read from memory, zero beyond its end
   assign mem_note  = oob_ff ? '0 : note_type'(rd_data);
   assign tone_freq = (src_ff == SRC_BG) ? mem_note.freq : freq_ff;

   // tone period from the divider, saturated to the timer width
   assign p_full = quotient - QUOT_W'(1);
   assign p_sat  = (p_full > QUOT_W'(PERIOD_MAX)) ? PERIOD_MAX : p_full[15:0];

   assign wr_en = cmd.exec && (op_ff == OP_WRITE) &&
                  ((BACKGROUND_DEPTH >= SONG_MAX) || (int'(idx_ff) < BACKGROUND_DEPTH));
   assign div_start = cmd.tone && status.tone_go;

   // next sequencer state
   always_comb begin
      len_in        = len_ff;
      loop_in       = loop_ff;
      bg_pos_in     = bg_pos_ff;
      bg_left_in    = bg_left_ff;
      bg_on_in      = bg_on_ff;
      fx_sel_in     = fx_sel_ff;
      fx_pos_in     = fx_pos_ff;
      fx_left_in    = fx_left_ff;
      fx_on_in      = fx_on_ff;
      resume_in     = resume_ff;
      saved_pos_in  = saved_pos_ff;
      saved_left_in = saved_left_ff;
      period_in     = period_ff;
      compare_in    = compare_ff;
      reloaded_in   = reloaded_ff;
      src_in        = src_ff;
      ld_left_in    = ld_left_ff;
      freq_in       = freq_ff;
      rd_pos        = bg_pos_ff;

      // decide what the item does and which note to load
      if (cmd.exec) begin
         reloaded_in = 1'b0;
         src_in      = SRC_NONE;
         ld_left_in  = 1'b0;
         case (op_ff)
            OP_TICK: begin
               if (fx_on_ff) begin
                  if (fx_left_ff > el_ff) begin
                     fx_left_in = fx_left_ff - el_ff;
                  end else if (fx_nxt >= fx_len(fx_sel_ff)) begin
                     // effect over: mute, then pick up the saved song
                     fx_on_in   = 1'b0;
                     fx_pos_in  = '0;
                     compare_in = '0;
                     if (resume_ff) begin
                        bg_on_in   = 1'b1;
                        bg_pos_in  = saved_pos_ff;
                        bg_left_in = saved_left_ff;
                        rd_pos     = saved_pos_ff;
                        src_in     = SRC_BG;
                     end
                  end else begin
                     fx_pos_in  = fx_nxt[FXPOS_W-1:0];
                     fx_left_in = fx_next_note.dur;
                     freq_in    = fx_next_note.freq;
                     src_in     = SRC_FX;
                  end
               end else if (bg_on_ff) begin
                  if (bg_left_ff > el_ff) begin
                     bg_left_in = bg_left_ff - el_ff;
                  end else if (bg_nxt >= eff_len && !loop_ff) begin
                     // song over
                     bg_on_in   = 1'b0;
                     bg_pos_in  = '0;
                     compare_in = '0;
                  end else begin
                     rd_pos     = (bg_nxt >= eff_len) ? '0 : bg_nxt[IDX_W-1:0];
                     bg_pos_in  = rd_pos;
                     ld_left_in = 1'b1;
                     src_in     = SRC_BG;
                  end
               end
            end
            OP_START: begin
               bg_pos_in  = start_pos;
               bg_on_in   = 1'b1;
               rd_pos     = start_pos;
               ld_left_in = 1'b1;
               src_in     = SRC_BG;
            end
            OP_EFFECT: begin
               if (id_ff < NUM_EFFECTS) begin
                  resume_in     = bg_on_ff;
                  saved_pos_in  = bg_pos_ff;
                  saved_left_in = bg_left_ff;
                  bg_on_in      = 1'b0;
                  fx_sel_in     = id_ff;
                  fx_pos_in     = '0;
                  fx_on_in      = 1'b1;
                  fx_left_in    = fx_first_note.dur;
                  freq_in       = fx_first_note.freq;
                  src_in        = SRC_FX;
               end
            end
            default: src_in = SRC_NONE;
         endcase
      end

      // note fetched: duration and rest handling
      if (cmd.tone) begin
         if (src_ff == SRC_BG && ld_left_ff) begin
            bg_left_in = mem_note.dur;
         end
         if (src_ff != SRC_NONE && tone_freq == '0) begin
            compare_in = '0;
         end
      end

      // divider finished: load the new tone
      if (cmd.commit) begin
         period_in   = p_sat;
         compare_in  = {1'b0, p_sat[15:1]};
         reloaded_in = 1'b1;
      end

      // register writes
      if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_LENGTH: begin
               len_in    = csr_wdata;
               bg_pos_in = '0;
               bg_on_in  = 1'b0;
            end
            CSR_LOOP: loop_in = csr_wdata[0];
            default:  loop_in = loop_ff;
         endcase
      end
   end

   // read position beyond the memory yields a silent note
   assign oob_in = (int'(rd_pos) >= BACKGROUND_DEPTH);

   // result register handshake
   assign rsp_valid_in = cmd.publish || (rsp_valid_ff && !rsp_ready);

   assign status.tone_go  = (src_ff != SRC_NONE) && (tone_freq != '0);
   assign status.div_done = div_done;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   // control and sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff        <= LEN_W'(1);
         loop_ff       <= 1'b0;
         bg_pos_ff     <= '0;
         bg_left_ff    <= '0;
         bg_on_ff      <= 1'b0;
         fx_sel_ff     <= '0;
         fx_pos_ff     <= '0;
         fx_left_ff    <= '0;
         fx_on_ff      <= 1'b0;
         resume_ff     <= 1'b0;
         saved_pos_ff  <= '0;
         saved_left_ff <= '0;
         period_ff     <= PERIOD_RST;
         compare_ff    <= '0;
         reloaded_ff   <= 1'b0;
         src_ff        <= SRC_NONE;
         ld_left_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         len_ff        <= len_in;
         loop_ff       <= loop_in;
         bg_pos_ff     <= bg_pos_in;
         bg_left_ff    <= bg_left_in;
         bg_on_ff      <= bg_on_in;
         fx_sel_ff     <= fx_sel_in;
         fx_pos_ff     <= fx_pos_in;
         fx_left_ff    <= fx_left_in;
         fx_on_ff      <= fx_on_in;
         resume_ff     <= resume_in;
         saved_pos_ff  <= saved_pos_in;
         saved_left_ff <= saved_left_in;
         period_ff     <= period_in;
         compare_ff    <= compare_in;
         reloaded_ff   <= reloaded_in;
         src_ff        <= src_in;
         ld_left_ff    <= ld_left_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff  <= op_type'(req_operation);
         el_ff  <= req_elapsed_ms;
         id_ff  <= req_effect_id;
         idx_ff <= req_note_index;
         fr_ff  <= req_note_frequency;
         du_ff  <= req_note_duration;
      end
      if (cmd.exec) begin
         oob_ff <= oob_in;
      end
      freq_ff <= freq_in;
      if (cmd.publish) begin
         rsp_period_ff  <= period_ff;
         rsp_compare_ff <= compare_ff;
         rsp_reload_ff  <= reloaded_ff;
         rsp_bg_ff      <= bg_on_ff;
         rsp_fx_ff      <= fx_on_ff;
      end
   end

   // background note memory
   tsq_ram #(
      .WIDTH (32),
      .DEPTH (BACKGROUND_DEPTH)
   ) u_notes (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (MAW'(idx_ff)),
      .wr_data ({fr_ff, du_ff}),
      .rd_addr (MAW'(rd_pos)),
      .rd_data (rd_data)
   );

   // tick rate over frequency
   tsq_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .divisor  (tone_freq),
      .quotient (quotient),
      .done     (div_done)
   );

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_period_reload     = rsp_period_ff;
   assign rsp_compare_value     = rsp_compare_ff;
   assign rsp_reload_event      = rsp_reload_ff;
   assign rsp_background_active = rsp_bg_ff;
   assign rsp_effect_active     = rsp_fx_ff;

endmodule

/* src/tone_sequencer_with_effect_preempt.sv */
`timescale 1ns / 1ps
// Timing: an item passes the states EXEC, TONE and DONE, and rsp_valid is
//   then registered; an item that loads a tone also passes DIV, which runs
//   the 20-step serial divider, and COMMIT. Flow: one item at a time; a
//   stalled result holds its item in DONE, so no new item is accepted.
// Reset: synchronous, active high; clears all control and sequencer state.
//   The note memory has no reset and no clearing pass.
// ----------------------------------------------------------------------------
// tone_sequencer_with_effect_preempt
// Two-voice PWM tone note sequencer: background song with effect pre-emption.
// ----------------------------------------------------------------------------
module tone_sequencer_with_effect_preempt #(
   parameter int BACKGROUND_DEPTH = 64
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [tsq_pkg::OP_W-1:0]      req_operation,
   input  logic [tsq_pkg::MS_W-1:0]      req_elapsed_ms,
   input  logic [tsq_pkg::FX_W-1:0]      req_effect_id,
   input  logic [tsq_pkg::IDX_W-1:0]     req_note_index,
   input  logic [tsq_pkg::FREQ_W-1:0]    req_note_frequency,
   input  logic [tsq_pkg::DUR_W-1:0]     req_note_duration,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [15:0]                   rsp_period_reload,
   output logic [15:0]                   rsp_compare_value,
   output logic                          rsp_reload_event,
   output logic                          rsp_background_active,
   output logic                          rsp_effect_active,
   input  logic                          csr_write_enable,
   input  logic                          csr_index,
   input  logic [tsq_pkg::LEN_W-1:0]     csr_wdata
);
   import tsq_pkg::*;

   ctrl_cmd_type    cmd;
   ctrl_status_type status;

   // sequencing
   tsq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   // state, memory and arithmetic
   tsq_datapath #(
      .BACKGROUND_DEPTH (BACKGROUND_DEPTH)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_operation         (req_operation),
      .req_elapsed_ms        (req_elapsed_ms),
      .req_effect_id         (req_effect_id),
      .req_note_index        (req_note_index),
      .req_note_frequency    (req_note_frequency),
      .req_note_duration     (req_note_duration),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_period_reload     (rsp_period_reload),
      .rsp_compare_value     (rsp_compare_value),
      .rsp_reload_event      (rsp_reload_event),
      .rsp_background_active (rsp_background_active),
      .rsp_effect_active     (rsp_effect_active)
   );

endmodule

/* src/tsq_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsq_checker
// Port-level checks of the tone sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module tsq_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_period_reload,
   input logic [15:0] rsp_compare_value,
   input logic        rsp_reload_event
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // a stalled result keeps its period and compare payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_period_reload) && $stable(rsp_compare_value))
      else $error("result payload changed while stalled");

   // a sounding tone always has a half-period compare
   a_half_period: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_compare_value != 16'd0 |->
         rsp_compare_value == {1'b0, rsp_period_reload[15:1]})
      else $error("compare is not half the period");

   // a reload never reports a muted tone
   a_reload_sounds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reload_event |-> rsp_compare_value != 16'd0)
      else $error("reload with muted compare");

endmodule

bind tone_sequencer_with_effect_preempt tsq_checker u_checker (.*);

/* sim/tb_tone_sequencer_with_effect_preempt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tone_sequencer_with_effect_preempt
// Self-checking bench for the two-voice tone sequencer. The note memory is
// filled first. A short directed table then covers the frequency and
// duration extremes, every operation, ignored effect ids, the resume and its
// cancel, and a resume past the song length. Random phases follow, each with
// its own song length, loop setting and handshake idling. Every result is
// compared with its typed table value or a cycle-free model in this file.
// ----------------------------------------------------------------------------
module tb_tone_sequencer_with_effect_preempt;
   import tsq_pkg::*;

   localparam int BG_DEPTH     = 64;
   localparam int SONG_CAP     = SONG_MAX;
   localparam int unsigned TICK_RATE = 1000000;
   localparam int NUM_PHASES   = 8;
   localparam int PHASE_ITEMS  = 82;
   localparam int MAX_REPORTS  = 10;

   // effect notes as {frequency, duration}, four slots per effect
   localparam logic [0:23][31:0] FX_ROM = {
      {16'd1200, 16'd30},  {16'd0,    16'd10},  32'd0,              32'd0,
      {16'd600,  16'd50},  {16'd400,  16'd80},  {16'd0,   16'd30},  32'd0,
      {16'd250,  16'd120}, {16'd0,    16'd40},  32'd0,              32'd0,
      {16'd900,  16'd60},  {16'd1100, 16'd60},  {16'd1300, 16'd100}, {16'd0, 16'd40},
      {16'd784,  16'd120}, {16'd988,  16'd120}, {16'd1175, 16'd220}, {16'd0, 16'd60},
      {16'd523,  16'd150}, {16'd494,  16'd150}, {16'd440,  16'd300}, {16'd0, 16'd80}
   };
   localparam logic [0:5][2:0] FX_NOTES = {3'd2, 3'd3, 3'd2, 3'd4, 3'd4, 3'd4};

   typedef struct packed {
      op_type      op;
      logic [15:0] elapsed;
      logic [2:0]  fx;
      logic [5:0]  idx;
      logic [15:0] freq;
      logic [15:0] dur;
   } tone_request_type;

   typedef struct packed {
      logic [15:0] period;
      logic [15:0] compare;
      logic        reload;
      logic        bg;
      logic        fx;
   } tone_result_type;

   typedef struct {
      logic             is_csr;
      csr_index_type    reg_sel;
      logic [6:0]       reg_val;
      tone_request_type item;
      logic             typed;
      tone_result_type  want;
   } dir_row_type;

   // dut ports
   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [OP_W-1:0]   req_operation = '0;
   logic [MS_W-1:0]   req_elapsed_ms = '0;
   logic [FX_W-1:0]   req_effect_id = '0;
   logic [IDX_W-1:0]  req_note_index = '0;
   logic [FREQ_W-1:0] req_note_frequency = '0;
   logic [DUR_W-1:0]  req_note_duration = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [15:0]       rsp_period_reload;
   logic [15:0]       rsp_compare_value;
   logic              rsp_reload_event;
   logic              rsp_background_active;
   logic              rsp_effect_active;
   logic              csr_write_enable = 1'b0;
   logic              csr_index = 1'b0;
   logic [LEN_W-1:0]  csr_wdata = '0;

   // sequencer model state
   logic [31:0] bg_notes [0:BG_DEPTH-1];
   logic [6:0]  bg_len_q;
   logic        bg_loop_q;
   logic [5:0]  bg_pos;
   logic [15:0] bg_left;
   logic        bg_playing;
   logic [2:0]  fx_sel;
   logic [1:0]  fx_pos;
   logic [15:0] fx_left;
   logic        fx_playing;
   logic        resume_flag;
   logic [5:0]  save_pos;
   logic [15:0] save_left;
   logic [15:0] period_q;
   logic [15:0] compare_q;
   logic        tone_loaded;

   tone_result_type expected_tones [$];
   dir_row_type     dir_rows [$];

   // bench control and statistics
   int  tx_idle_pct = 0;
   int  rx_stall_pct = 0;
   logic            cur_typed = 1'b0;
   tone_result_type cur_want = '0;
   int  mismatches = 0;
   int  transfers_in = 0;
   int  results_out = 0;
   int  tone_loads = 0;
   int  bg_starts = 0;
   int  fx_plays = 0;

   tone_sequencer_with_effect_preempt #(
      .BACKGROUND_DEPTH(BG_DEPTH)
   ) DUT (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_operation         (req_operation),
      .req_elapsed_ms        (req_elapsed_ms),
      .req_effect_id         (req_effect_id),
      .req_note_index        (req_note_index),
      .req_note_frequency    (req_note_frequency),
      .req_note_duration     (req_note_duration),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_period_reload     (rsp_period_reload),
      .rsp_compare_value     (rsp_compare_value),
      .rsp_reload_event      (rsp_reload_event),
      .rsp_background_active (rsp_background_active),
      .rsp_effect_active     (rsp_effect_active),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   // clock
   initial begin
      forever #4 clock = ~clock;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("tone_sequencer_with_effect_preempt verification failed");
      $finish;
   end

   // ------------------------------------------------------------------------
   // sequencer model
   // ------------------------------------------------------------------------

   function automatic int unsigned song_length();
      int unsigned n;
      n = bg_len_q;
      if (n == 0) n = 1;
      if (n > SONG_CAP) n = SONG_CAP;
      return n;
   endfunction

   // frequency 0 mutes, anything else loads a new period
   function automatic void load_tone(input logic [15:0] f);
      int unsigned p;
      if (f == 16'd0) begin
         compare_q = 16'd0;
         return;
      end
      p = TICK_RATE / f - 1;
      if (p > 32'hFFFF) p = 32'hFFFF;
      period_q    = p[15:0];
      compare_q   = p[16:1];
      tone_loaded = 1'b1;
   endfunction

   function automatic void next_song_note();
      int unsigned nxt;
      nxt = bg_pos + 32'd1;
      if (nxt >= song_length()) begin
         if (bg_loop_q) begin
            nxt = 0;
         end else begin
            bg_playing = 1'b0;
            bg_pos     = 6'd0;
            load_tone(16'd0);
            return;
         end
      end
      bg_pos  = nxt[5:0];
      bg_left = bg_notes[bg_pos][15:0];
      load_tone(bg_notes[bg_pos][31:16]);
   endfunction

   function automatic void next_effect_note();
      int unsigned nxt;
      logic [31:0] note;
      nxt = fx_pos + 32'd1;
      if (fx_sel >= NUM_EFFECTS || nxt >= FX_NOTES[fx_sel]) begin
         fx_playing = 1'b0;
         fx_pos     = 2'd0;
         load_tone(16'd0);
         return;
      end
      fx_pos  = nxt[1:0];
      note    = FX_ROM[fx_sel * 4 + fx_pos];
      fx_left = note[15:0];
      load_tone(note[31:16]);
   endfunction

   // the effect owns the tick while it plays
   function automatic void count_down(input logic [15:0] el);
      if (fx_playing) begin
         if (fx_left > el) fx_left = fx_left - el;
         else next_effect_note();
         if (!fx_playing && resume_flag) begin
            bg_playing = 1'b1;
            bg_pos     = save_pos;
            bg_left    = save_left;
            load_tone(bg_notes[bg_pos][31:16]);
         end
         return;
      end
      if (bg_playing) begin
         if (bg_left > el) bg_left = bg_left - el;
         else next_song_note();
      end
   endfunction

   function automatic void apply_csr(input csr_index_type sel, input logic [6:0] val);
      if (sel == CSR_LENGTH) begin
         bg_len_q   = val;
         bg_pos     = 6'd0;
         bg_playing = 1'b0;
      end else begin
         bg_loop_q = val[0];
      end
   endfunction

   function automatic void reset_sequencer();
      bg_len_q    = 7'd1;
      bg_loop_q   = 1'b0;
      bg_pos      = '0;
      bg_left     = '0;
      bg_playing  = 1'b0;
      fx_sel      = '0;
      fx_pos      = '0;
      fx_left     = '0;
      fx_playing  = 1'b0;
      resume_flag = 1'b0;
      save_pos    = '0;
      save_left   = '0;
      period_q    = 16'd1000;
      compare_q   = '0;
      tone_loaded = 1'b0;
   endfunction

   function automatic tone_result_type advance_sequencer(input tone_request_type it);
      tone_result_type r;
      logic [31:0] note;
      tone_loaded = 1'b0;
      case (it.op)
         OP_TICK: begin
            count_down(it.elapsed);
         end
         OP_START: begin
            if (bg_pos >= song_length()) bg_pos = 6'd0;
            bg_playing = 1'b1;
            bg_left    = bg_notes[bg_pos][15:0];
            load_tone(bg_notes[bg_pos][31:16]);
         end
         OP_EFFECT: begin
            if (it.fx < NUM_EFFECTS) begin
               resume_flag = bg_playing;
               save_pos    = bg_pos;
               save_left   = bg_left;
               bg_playing  = 1'b0;
               fx_sel      = it.fx;
               fx_pos      = 2'd0;
               fx_playing  = 1'b1;
               note        = FX_ROM[it.fx * 4];
               fx_left     = note[15:0];
               load_tone(note[31:16]);
            end
         end
         default: begin
            bg_notes[it.idx] = {it.freq, it.dur};
         end
      endcase
      r.period  = period_q;
      r.compare = compare_q;
      r.reload  = tone_loaded;
      r.bg      = bg_playing;
      r.fx      = fx_playing;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------

   // mostly short notes and short ticks so songs and effects keep moving
   function automatic tone_request_type random_item();
      tone_request_type it;
      int unsigned r;
      int unsigned s;
      it.elapsed = 16'($urandom);
      it.fx      = 3'($urandom);
      it.idx     = 6'($urandom);
      it.freq    = 16'($urandom);
      it.dur     = 16'($urandom);
      r = $urandom_range(0, 99);
      s = $urandom_range(0, 99);
      if (r < 55) begin
         it.op = OP_TICK;
         if (s < 10) it.elapsed = 16'd0;
         else if (s < 85) it.elapsed = 16'($urandom_range(0, 150));
      end else if (r < 65) begin
         it.op = OP_START;
      end else if (r < 77) begin
         it.op = OP_EFFECT;
         if (s < 10) it.fx = 3'($urandom_range(6, 7));
         else it.fx = 3'($urandom_range(0, 5));
      end else begin
         it.op = OP_WRITE;
         if (s < 10) it.freq = 16'd0;
         else if (s < 20) begin
            case ($urandom_range(0, 3))
               0:       it.freq = 16'd1;
               1:       it.freq = 16'd15;
               2:       it.freq = 16'd16;
               default: it.freq = 16'hFFFF;
            endcase
         end else if (s >= 30) it.freq = 16'($urandom_range(100, 5000));
         s = $urandom_range(0, 99);
         if (s < 10) it.dur = 16'd0;
         else if (s < 90) it.dur = 16'($urandom_range(0, 250));
      end
      return it;
   endfunction

   function automatic void add_item(input logic typed, input op_type op,
                                    input int el, input int id, input int idx,
                                    input int fr, input int du, input int p,
                                    input int c, input int rl, input int b, input int f);
      dir_row_type row;
      row.is_csr         = 1'b0;
      row.reg_sel        = CSR_LENGTH;
      row.reg_val        = '0;
      row.item.op        = op;
      row.item.elapsed   = 16'(el);
      row.item.fx        = 3'(id);
      row.item.idx       = 6'(idx);
      row.item.freq      = 16'(fr);
      row.item.dur       = 16'(du);
      row.typed          = typed;
      row.want.period    = 16'(p);
      row.want.compare   = 16'(c);
      row.want.reload    = 1'(rl);
      row.want.bg        = 1'(b);
      row.want.fx        = 1'(f);
      dir_rows.push_back(row);
   endfunction

   function automatic void add_csr(input csr_index_type sel, input logic [6:0] val);
      dir_row_type row;
      row.is_csr  = 1'b1;
      row.reg_sel = sel;
      row.reg_val = val;
      row.item    = '0;
      row.typed   = 1'b0;
      row.want    = '0;
      dir_rows.push_back(row);
   endfunction

   // one transfer; returns at the edge that accepts it
   task automatic send_item(input tone_request_type it, input logic typed,
                            input tone_result_type want);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid          <= 1'b1;
      req_operation      <= it.op;
      req_elapsed_ms     <= it.elapsed;
      req_effect_id      <= it.fx;
      req_note_index     <= it.idx;
      req_note_frequency <= it.freq;
      req_note_duration  <= it.dur;
      cur_typed          <= typed;
      cur_want           <= want;
      do @(posedge clock); while (!req_ready);
   endtask

   // stop sending and let every outstanding result come back
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_tones.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type sel, input logic [6:0] val);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= sel;
      csr_wdata        <= val;
      apply_csr(sel, val);
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // receiver stalls
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
   end

   // ------------------------------------------------------------------------
   // scoreboard: check results, then predict newly accepted items
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      tone_result_type  got;
      tone_result_type  want;
      tone_result_type  pred;
      tone_request_type it;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got.period  = rsp_period_reload;
            got.compare = rsp_compare_value;
            got.reload  = rsp_reload_event;
            got.bg      = rsp_background_active;
            got.fx      = rsp_effect_active;
            results_out++;
            if (got.reload) tone_loads++;
            if (expected_tones.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: result with nothing pending: period %0d compare %0d",
                           $realtime, got.period, got.compare);
            end else begin
               want = expected_tones.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS) begin
                     $display("%0t: result %0d mismatch", $realtime, results_out);
                     $display("  expected period %0d compare %0d reload %0b bg %0b fx %0b",
                              want.period, want.compare, want.reload, want.bg, want.fx);
                     $display("  got      period %0d compare %0d reload %0b bg %0b fx %0b",
                              got.period, got.compare, got.reload, got.bg, got.fx);
                  end
               end
            end
         end
         if (req_valid && req_ready) begin
            it.op      = op_type'(req_operation);
            it.elapsed = req_elapsed_ms;
            it.fx      = req_effect_id;
            it.idx     = req_note_index;
            it.freq    = req_note_frequency;
            it.dur     = req_note_duration;
            transfers_in++;
            if (it.op == OP_START) bg_starts++;
            if (it.op == OP_EFFECT) fx_plays++;
            pred = advance_sequencer(it);
            expected_tones.push_back(cur_typed ? cur_want : pred);
         end
      end
   end

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      tone_request_type it;
      int counted;
      logic paused;
      int p_len [NUM_PHASES];
      int p_loop [NUM_PHASES];
      int p_tx [NUM_PHASES];
      int p_rx [NUM_PHASES];

      p_len  = '{4, 64, 0, 127, 1, 17, 33, 8};
      p_loop = '{1, 0, 1, 0, 1, 1, 0, 1};
      p_tx   = '{0, 52, 0, 10, 0, 52, 0, 10};
      p_rx   = '{0, 0, 52, 10, 0, 0, 52, 10};
      paused = 1'b0;
      reset_sequencer();

      // directed table: typed expectations only where obvious
      add_item(1, OP_TICK,   0,     0, 0,  0,     0,     1000,  0,     0, 0, 0);
      add_item(1, OP_WRITE,  0,     0, 0,  1,     0,     1000,  0,     0, 0, 0);
      add_item(1, OP_START,  0,     0, 0,  0,     0,     65535, 32767, 1, 1, 0);
      // zero duration ends on a tick of zero, song of one note stops
      add_item(1, OP_TICK,   0,     0, 0,  0,     0,     65535, 0,     0, 0, 0);
      add_item(1, OP_WRITE,  0,     0, 63, 65535, 65535, 65535, 0,     0, 0, 0);
      // effect ids past the table are ignored
      add_item(1, OP_EFFECT, 0,     6, 0,  0,     0,     65535, 0,     0, 0, 0);
      add_item(1, OP_EFFECT, 0,     7, 0,  0,     0,     65535, 0,     0, 0, 0);
      add_item(1, OP_START,  0,     0, 0,  0,     0,     65535, 32767, 1, 1, 0);
      add_item(1, OP_EFFECT, 0,     0, 0,  0,     0,     832,   416,   1, 0, 1);
      // second effect cancels the resume
      add_item(1, OP_EFFECT, 0,     1, 0,  0,     0,     1665,  832,   1, 0, 1);
      add_item(0, OP_TICK,   65535, 0, 0,  0,     0,     0, 0, 0, 0, 0);
      add_item(0, OP_TICK,   65535, 0, 0,  0,     0,     0, 0, 0, 0, 0);
      add_item(0, OP_TICK,   65535, 0, 0,  0,     0,     0, 0, 0, 0, 0);
      // resume lands past a shortened song, then a start rewinds
      add_csr(CSR_LENGTH, 7'd8);
      add_csr(CSR_LOOP, 7'h7F);
      add_item(0, OP_START,  0,     0, 0,  0,     0,     0, 0, 0, 0, 0);
      add_item(0, OP_TICK,   65535, 0, 0,  0,     0,     0, 0, 0, 0, 0);
      add_item(0, OP_TICK,   65535, 0, 0,  0,     0,     0, 0, 0, 0, 0);
      add_item(0, OP_EFFECT, 0,     2, 0,  0,     0,     0, 0, 0, 0, 0);
      add_csr(CSR_LENGTH, 7'd2);
      add_item(0, OP_TICK,   65535, 0, 0,  0,     0,     0, 0, 0, 0, 0);
      add_item(0, OP_TICK,   65535, 0, 0,  0,     0,     0, 0, 0, 0, 0);
      add_item(0, OP_START,  0,     0, 0,  0,     0,     0, 0, 0, 0, 0);
      // start during an effect, effect keeps the tick
      add_item(0, OP_EFFECT, 0,     3, 0,  0,     0,     0, 0, 0, 0, 0);
      add_item(0, OP_START,  0,     0, 0,  0,     0,     0, 0, 0, 0, 0);
      add_item(0, OP_TICK,   5,     0, 0,  0,     0,     0, 0, 0, 0, 0);
      add_item(0, OP_EFFECT, 0,     4, 0,  0,     0,     0, 0, 0, 0, 0);
      add_item(0, OP_EFFECT, 0,     5, 0,  0,     0,     0, 0, 0, 0, 0);
      add_item(0, OP_WRITE,  0,     0, 0,  16,    65535, 0, 0, 0, 0, 0);

      // reset
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // fill the whole note memory before anything can read it
      for (int i = 0; i < BG_DEPTH; i++) begin
         it     = random_item();
         it.op  = OP_WRITE;
         it.idx = 6'(i);
         send_item(it, 1'b0, '0);
      end

      // directed part
      foreach (dir_rows[i]) begin
         if (dir_rows[i].is_csr) begin
            wait_drained();
            write_csr(dir_rows[i].reg_sel, dir_rows[i].reg_val);
         end else begin
            send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
         end
      end

      // random phases
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         wait_drained();
         write_csr(CSR_LENGTH, 7'(p_len[ph]));
         write_csr(CSR_LOOP, {6'($urandom), 1'(p_loop[ph])});
         tx_idle_pct  = p_tx[ph];
         rx_stall_pct = p_rx[ph];
         counted = 0;
         while (counted < PHASE_ITEMS) begin
            it = random_item();
            send_item(it, 1'b0, '0);
            if (!(it.op == OP_EFFECT && it.fx >= NUM_EFFECTS)) counted++;
            // sender holds off once until the pipe is empty
            if (ph == 1 && counted == PHASE_ITEMS / 2 && !paused) begin
               paused = 1'b1;
               wait_drained();
            end
         end
      end

      // drain and report
      wait_drained();
      repeat (30) @(posedge clock);
      if (expected_tones.size() != 0) begin
         mismatches++;
         $display("%0d results never arrived", expected_tones.size());
      end
      $display("run covered %0d transfers over %0d phases and the directed table",
               transfers_in, NUM_PHASES);
      $display("  %0d tone loads, %0d background starts, %0d effect requests, %0d mismatches",
               tone_loads, bg_starts, fx_plays, mismatches);
      if (mismatches == 0) begin
         $display("tone_sequencer_with_effect_preempt verification clean");
      end else begin
         $display("tone_sequencer_with_effect_preempt verification failed");
      end
      $finish;
   end

endmodule
